// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/uqp_pkg.sv =====
// types, constants and helper functions of the query string parser
`timescale 1ns / 1ps

package uqp_pkg;

    localparam int MAX_RES = 8;
    localparam int CNT_W   = 4;
    localparam int IDX_W   = 3;
    localparam int MIN_LEN = 3;

    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_AMP = 8'h26;
    localparam logic [7:0] CH_QM  = 8'h3F;

    typedef enum logic [2:0] {
        K_NAME          = 3'd0,
        K_VALUE         = 3'd1,
        K_PAIR_END      = 3'd2,
        K_PAIR_DROP     = 3'd3,
        K_RESTART_NAME  = 3'd4,
        K_RESTART_VALUE = 3'd5,
        K_END_OK        = 3'd6,
        K_END_SHORT     = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HEX  = 2'd2
    } t_phase;

    typedef struct packed {
        logic       in_value;
        t_phase     phase;
        logic [7:0] first_hex;
    } t_pstate;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
    } t_res;

    typedef struct packed {
        t_res [MAX_RES-1:0] ent;
        logic [CNT_W-1:0]   cnt;
    } t_list;

    localparam t_pstate PS_RESET = '{in_value: 1'b0, phase: PH_IDLE, first_hex: 8'h00};

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // append one result, extra results beyond the list size are dropped
    function automatic t_list push(input t_list l, input t_kind k, input logic [7:0] b);
        t_list r;
        r = l;
        if (r.cnt < CNT_W'(MAX_RES)) begin
            r.ent[r.cnt[IDX_W-1:0]].data = b;
            r.ent[r.cnt[IDX_W-1:0]].kind = k;
            r.cnt = r.cnt + CNT_W'(1);
        end
        return r;
    endfunction

endpackage

// ===== sv/uqp_feed.sv =====
// one character step: escape decoding and delimiter handling
`timescale 1ns / 1ps

module uqp_feed (
    input  logic            i_en,
    input  logic [7:0]      i_byte,
    input  uqp_pkg::t_pstate i_ps,
    input  uqp_pkg::t_list  i_list,
    output uqp_pkg::t_pstate o_ps,
    output uqp_pkg::t_list  o_list
);
    import uqp_pkg::*;

    t_pstate    ps;
    t_list      lst;
    logic [4:0] hv;
    logic [4:0] hh;
    logic       do_plain;
    t_kind      dkind;

    always_comb begin
        ps       = i_ps;
        lst      = i_list;
        hv       = hex_val(i_byte);
        hh       = hex_val(i_ps.first_hex);
        do_plain = 1'b0;
        dkind    = i_ps.in_value ? K_VALUE : K_NAME;
        if (i_en) begin
            case (i_ps.phase)
                PH_PCT: begin
                    if (hv[4]) begin
                        ps.first_hex = i_byte;
                        ps.phase     = PH_HEX;
                    end else begin
                        ps.phase = PH_IDLE;
                        lst      = push(lst, dkind, CH_PCT);
                        do_plain = 1'b1;
                    end
                end
                PH_HEX: begin
                    ps.phase = PH_IDLE;
                    if (hv[4] && hh[4]) begin
                        lst = push(lst, dkind, {hh[3:0], hv[3:0]});
                    end else begin
                        lst      = push(lst, dkind, CH_PCT);
                        lst      = push(lst, dkind, i_ps.first_hex);
                        do_plain = 1'b1;
                    end
                end
                default: begin
                    // unused phase code behaves as no escape pending
                    ps.phase = PH_IDLE;
                    do_plain = 1'b1;
                end
            endcase
            if (do_plain) begin
                case (i_byte)
                    CH_PCT: ps.phase = PH_PCT;
                    CH_EQ: begin
                        if (ps.in_value) begin
                            lst = push(lst, K_RESTART_VALUE, 8'h00);
                        end else begin
                            ps.in_value = 1'b1;
                        end
                    end
                    CH_AMP: begin
                        lst = push(lst, ps.in_value ? K_PAIR_END : K_PAIR_DROP, 8'h00);
                        ps.in_value = 1'b0;
                    end
                    CH_QM: begin
                        if (ps.in_value) begin
                            lst = push(lst, dkind, i_byte);
                        end else begin
                            lst = push(lst, K_RESTART_NAME, 8'h00);
                        end
                    end
                    default: lst = push(lst, dkind, i_byte);
                endcase
            end
        end
    end

    assign o_ps   = ps;
    assign o_list = lst;

endmodule

// ===== sv/uqp_close.sv =====
// end of string handling and lead byte counting
`timescale 1ns / 1ps

module uqp_close (
    input  logic            i_lead,
    input  logic            i_last,
    input  logic [1:0]      i_lead_cnt,
    input  uqp_pkg::t_pstate i_ps,
    input  uqp_pkg::t_list  i_list,
    output uqp_pkg::t_pstate o_ps,
    output uqp_pkg::t_list  o_list,
    output logic [1:0]      o_lead_cnt
);
    import uqp_pkg::*;

    t_pstate    ps;
    t_list      lst;
    logic [1:0] lc;
    t_kind      dkind;

    always_comb begin
        ps    = i_ps;
        lst   = i_list;
        lc    = i_lead_cnt;
        dkind = i_ps.in_value ? K_VALUE : K_NAME;
        if (i_lead) begin
            if (i_last) begin
                lst = push(lst, K_END_SHORT, 8'h00);
                ps  = PS_RESET;
                lc  = 2'd0;
            end else begin
                lc = i_lead_cnt + 2'd1;
            end
        end else if (i_last) begin
            // flush a pending escape literally
            case (i_ps.phase)
                PH_PCT: lst = push(lst, dkind, CH_PCT);
                PH_HEX: begin
                    lst = push(lst, dkind, CH_PCT);
                    lst = push(lst, dkind, i_ps.first_hex);
                end
                default: lst = lst;
            endcase
            lst = push(lst, i_ps.in_value ? K_PAIR_END : K_PAIR_DROP, 8'h00);
            lst = push(lst, K_END_OK, 8'h00);
            ps  = PS_RESET;
            lc  = 2'd0;
        end else begin
            lc = 2'(MIN_LEN);
        end
    end

    assign o_ps       = ps;
    assign o_list     = lst;
    assign o_lead_cnt = lc;

endmodule

// ===== sv/url_query_parameter_parser_core.sv =====
// top level: url-encoded query string parser with result queue
// an accepted byte waits in the input register; its results load the queue once that is free
// throughput: one byte per cycle while each byte yields at most one result and output is ready;
// a byte that yields several results stalls the input side until only its last one is left;
// one result drains per cycle while the output is ready; the held-back lead bytes yield none
// reset: synchronous active-low, clears parser state, lead count and both handshake stages
`timescale 1ns / 1ps

module url_query_parameter_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
    input  logic        s_axis_tlast,  // in_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [2:0] out_kind, [10:3] out_byte, [15:11] zero
    output logic        m_axis_tlast   // out_last
);
    import uqp_pkg::*;

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // parser state
    t_pstate    r_ps;
    logic [1:0] r_lead_cnt;
    logic [7:0] r_lead [2];   // first two bytes of a string, replayed on the third

    // result queue, entry 0 is on the output
    t_list      r_buf;

    logic       in_acc;
    logic       out_acc;
    logic       buf_free;
    logic       take;
    logic       lead;
    logic       replay;

    t_pstate    ps_f0, ps_f1, ps_f2, n_ps;
    t_list      ls_f0, ls_f1, ls_f2, n_list;
    logic [1:0] n_lead_cnt;

    // handshakes
    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign buf_free = (r_buf.cnt == CNT_W'(0)) ||
                      ((r_buf.cnt == CNT_W'(1)) && m_axis_tready);
    assign take     = r_in_valid && buf_free;
    assign s_axis_tready = !r_in_valid || buf_free;
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    // the first two bytes of a string are only stored
    assign lead   = r_lead_cnt < 2'(MIN_LEN - 1);
    assign replay = r_lead_cnt == 2'(MIN_LEN - 1);

    // replay of lead byte 0
    uqp_feed u_feed0 (
        .i_en   (replay),
        .i_byte (r_lead[0]),
        .i_ps   (r_ps),
        .i_list ('0),
        .o_ps   (ps_f0),
        .o_list (ls_f0)
    );

    // replay of lead byte 1
    uqp_feed u_feed1 (
        .i_en   (replay),
        .i_byte (r_lead[1]),
        .i_ps   (ps_f0),
        .i_list (ls_f0),
        .o_ps   (ps_f1),
        .o_list (ls_f1)
    );

    // current byte
    uqp_feed u_feed2 (
        .i_en   (!lead),
        .i_byte (r_in_byte),
        .i_ps   (ps_f1),
        .i_list (ls_f1),
        .o_ps   (ps_f2),
        .o_list (ls_f2)
    );

    // end markers, too-short check, lead counting
    uqp_close u_close (
        .i_lead     (lead),
        .i_last     (r_in_last),
        .i_lead_cnt (r_lead_cnt),
        .i_ps       (ps_f2),
        .i_list     (ls_f2),
        .o_ps       (n_ps),
        .o_list     (n_list),
        .o_lead_cnt (n_lead_cnt)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_acc || (r_in_valid && !take);
        end
        if (in_acc) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // parser state advances when the held byte moves into the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps       <= PS_RESET;
            r_lead_cnt <= 2'd0;
        end else if (take) begin
            r_ps       <= n_ps;
            r_lead_cnt <= n_lead_cnt;
        end
        if (take && lead) begin
            r_lead[r_lead_cnt[0]] <= r_in_byte;
        end
    end

    // result queue: load a whole list, then shift one entry per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf.cnt <= '0;
        end else if (take) begin
            r_buf.cnt <= n_list.cnt;
        end else if (out_acc) begin
            r_buf.cnt <= r_buf.cnt - CNT_W'(1);
        end
        if (take) begin
            r_buf.ent <= n_list.ent;
        end else if (out_acc) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                r_buf.ent[i] <= r_buf.ent[i+1];
            end
        end
    end

    assign m_axis_tvalid = r_buf.cnt != CNT_W'(0);
    assign m_axis_tlast  = r_buf.cnt == CNT_W'(1);
    assign m_axis_tdata  = {5'd0, r_buf.ent[0].data, r_buf.ent[0].kind};

endmodule

// ===== sv/uqp_checker.sv =====
// port-level checks of the query string parser, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uqp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import uqp_pkg::*;

    logic is_data;
    logic is_end;

    assign is_data = (m_axis_tdata[2:0] == K_NAME) || (m_axis_tdata[2:0] == K_VALUE);
    assign is_end  = (m_axis_tdata[2:0] == K_END_OK) || (m_axis_tdata[2:0] == K_END_SHORT);

    // a stalled result holds
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

    // marker results carry a zero byte
    `ASSERT_IMP(a_marker_zero, i_clk, i_rst_n, m_axis_tvalid && !is_data,
        m_axis_tdata[10:3] == 8'h00, "marker result with nonzero byte")

    // padding bits stay zero
    `ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[15:11] == 5'd0, "padding bits set")

    // end of string is always the final result of its byte
    `ASSERT_IMP(a_end_last, i_clk, i_rst_n, m_axis_tvalid && is_end,
        m_axis_tlast, "end marker without tlast")

    // input is only held off while results are waiting
    `ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !s_axis_tready,
        m_axis_tvalid, "input stalled with empty output")

endmodule

bind url_query_parameter_parser_core uqp_checker u_uqp_checker (.*);

// ===== dv/tb_url_query_parameter_parser_core.sv =====
// self-checking testbench for the url-encoded query string parser core
`timescale 1ns / 1ps

module tb_url_query_parameter_parser_core;

    import uqp_pkg::*;

    localparam int ITEM_TARGET = 450;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 20;

    // one raw character waiting to be sent, with its pacing
    typedef struct {
        logic [7:0]  data;
        logic        is_last;
        int unsigned gap;
        bit          drain;
    } t_raw_char;

    // one decoded token expected on the output stream
    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        logic       is_last;
    } t_token;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] in_byte
    logic        s_axis_tlast = 1'b0;   // in_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [2:0] out_kind, [10:3] out_byte, [15:11] zero
    logic        m_axis_tlast;          // out_last

    url_query_parameter_parser_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    t_raw_char  raw_chars[$];
    t_token     exp_tokens[$];
    logic [7:0] build_buf[$];
    int         fail_cnt = 0;
    int         cycle_cnt = 0;

    // decoder state of the predictor
    logic       pr_in_value;
    t_phase     pr_phase;
    logic [7:0] pr_first_hex;
    logic [1:0] pr_lead_cnt;
    logic [7:0] pr_lead[2];

    // tokens produced by the current transaction
    t_kind      step_kind[MAX_RES];
    logic [7:0] step_data[MAX_RES];
    int         step_n;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    task automatic clear_decoder();
        pr_in_value = 1'b0;
        pr_phase = PH_IDLE;
        pr_first_hex = 8'h00;
        pr_lead_cnt = 2'd0;
    endtask

    // tokens past the block's result limit are lost
    task automatic tok_add(input t_kind k, input logic [7:0] b);
        if (step_n < MAX_RES) begin
            step_kind[step_n] = k;
            step_data[step_n] = b;
            step_n++;
        end
    endtask

    task automatic tok_data(input logic [7:0] b);
        tok_add(pr_in_value ? K_VALUE : K_NAME, b);
    endtask

    // a character outside of any escape sequence
    task automatic literal_char(input logic [7:0] c);
        if (c == CH_PCT) begin
            pr_phase = PH_PCT;
        end else if (c == CH_EQ) begin
            if (pr_in_value) tok_add(K_RESTART_VALUE, 8'h00);
            else pr_in_value = 1'b1;
        end else if (c == CH_AMP) begin
            tok_add(pr_in_value ? K_PAIR_END : K_PAIR_DROP, 8'h00);
            pr_in_value = 1'b0;
        end else if (c == CH_QM && !pr_in_value) begin
            tok_add(K_RESTART_NAME, 8'h00);
        end else begin
            tok_data(c);
        end
    endtask

    task automatic scan_char(input logic [7:0] c);
        int nib;
        int hi;
        nib = hex_digit(c);
        case (pr_phase)
            PH_PCT: begin
                if (nib >= 0) begin
                    pr_first_hex = c;
                    pr_phase = PH_HEX;
                end else begin
                    // broken escape: the percent sign goes out as is
                    pr_phase = PH_IDLE;
                    tok_data(CH_PCT);
                    literal_char(c);
                end
            end
            PH_HEX: begin
                hi = hex_digit(pr_first_hex);
                pr_phase = PH_IDLE;
                if (nib >= 0 && hi >= 0) begin
                    tok_data(8'((hi << 4) | nib));
                end else begin
                    tok_data(CH_PCT);
                    tok_data(pr_first_hex);
                    literal_char(c);
                end
            end
            default: begin
                pr_phase = PH_IDLE;
                literal_char(c);
            end
        endcase
    endtask

    // end of string: flush a cut escape, close the pair, report the end
    task automatic close_string();
        if (pr_phase == PH_PCT) begin
            tok_data(CH_PCT);
        end else if (pr_phase == PH_HEX) begin
            tok_data(CH_PCT);
            tok_data(pr_first_hex);
        end
        tok_add(pr_in_value ? K_PAIR_END : K_PAIR_DROP, 8'h00);
        tok_add(K_END_OK, 8'h00);
        clear_decoder();
    endtask

    // expected tokens of one accepted input character
    task automatic decode_char(input logic [7:0] c, input logic is_last);
        t_token t;
        step_n = 0;
        if (pr_lead_cnt < MIN_LEN - 1) begin
            // first two characters are held back until the length is known
            pr_lead[pr_lead_cnt[0]] = c;
            pr_lead_cnt++;
            if (is_last) begin
                tok_add(K_END_SHORT, 8'h00);
                clear_decoder();
            end
        end else begin
            if (pr_lead_cnt == MIN_LEN - 1) begin
                scan_char(pr_lead[0]);
                scan_char(pr_lead[1]);
                pr_lead_cnt = 2'(MIN_LEN);
            end
            scan_char(c);
            if (is_last) close_string();
        end
        for (int i = 0; i < step_n; i++) begin
            t.kind = step_kind[i];
            t.data = step_data[i];
            t.is_last = (i == step_n - 1);
            exp_tokens.push_back(t);
        end
    endtask

    // mostly short stalls, now and then a long one
    function automatic int unsigned pick_stall();
        if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 65) return 0;
        return pick_stall();
    endfunction

    function automatic logic [7:0] hex_char();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'("0" + v);
        if ($urandom_range(0, 1) == 1) return 8'("a" + v - 10);
        return 8'("A" + v - 10);
    endfunction

    function automatic logic [7:0] alnum_char();
        if ($urandom_range(0, 1) == 1) return 8'("a" + $urandom_range(0, 25));
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // delimiter-heavy character mix for noise strings
    function automatic logic [7:0] noise_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return alnum_char();
        if (r < 45) return hex_char();
        if (r < 57) return CH_PCT;
        if (r < 66) return CH_EQ;
        if (r < 75) return CH_AMP;
        if (r < 82) return CH_QM;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) build_buf.push_back(s[i]);
    endtask

    // name or value content, sometimes with a well-formed escape
    task automatic push_field(input int unsigned len, input bit in_val);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    build_buf.push_back(CH_PCT);
                    build_buf.push_back(hex_char());
                    build_buf.push_back(hex_char());
                end
                2: build_buf.push_back(in_val ? CH_QM : 8'($urandom_range(0, 255)));
                default: build_buf.push_back(alnum_char());
            endcase
        end
    endtask

    // move the built string to the send queue, last flag on its final character
    task automatic flush_string(input bit burst, input bit drain);
        t_raw_char rc;
        if (build_buf.size() == 0) build_buf.push_back(alnum_char());
        for (int i = 0; i < build_buf.size(); i++) begin
            rc.data = build_buf[i];
            rc.is_last = (i == build_buf.size() - 1);
            rc.gap = burst ? 0 : pick_gap();
            rc.drain = drain && (i == 0);
            raw_chars.push_back(rc);
        end
        build_buf.delete();
    endtask

    task automatic build_random_string(input bit drain);
        int unsigned r;
        int unsigned npairs;
        bit burst;
        r = $urandom_range(0, 99);
        burst = ($urandom_range(0, 3) == 0);
        if (r < 70) begin
            // well-formed pairs with random content
            npairs = $urandom_range(1, 4);
            for (int p = 0; p < npairs; p++) begin
                if (p > 0) build_buf.push_back(CH_AMP);
                push_field($urandom_range(0, 4), 1'b0);
                if ($urandom_range(0, 9) == 0) build_buf.push_back(CH_QM);
                if ($urandom_range(0, 9) != 0) begin
                    build_buf.push_back(CH_EQ);
                    push_field($urandom_range(0, 5), 1'b1);
                    if ($urandom_range(0, 9) == 0) begin
                        build_buf.push_back(CH_EQ);
                        push_field($urandom_range(0, 3), 1'b1);
                    end
                end
            end
        end else if (r < 85) begin
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
            for (int i = 0; i < r; i++) build_buf.push_back(noise_char());
        end else if (r < 93) begin
            r = $urandom_range(1, 10);
            for (int i = 0; i < r; i++) build_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            // too short to decode
            r = $urandom_range(1, 2);
            for (int i = 0; i < r; i++) build_buf.push_back(noise_char());
        end
        flush_string(burst, drain);
    endtask

    // sender: presents queued characters, predicts on every accepted transaction
    t_raw_char   tx_cur;
    logic        tx_busy = 1'b0;
    int unsigned tx_gap_cnt = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_busy = 1'b0;
            tx_gap_cnt = 0;
            clear_decoder();
            s_axis_tvalid <= 1'b0;
        end else begin
            if (tx_busy && s_axis_tready) begin
                decode_char(tx_cur.data, tx_cur.is_last);
                tx_busy = 1'b0;
            end
            if (!tx_busy && raw_chars.size() != 0) begin
                if (tx_gap_cnt < raw_chars[0].gap) begin
                    tx_gap_cnt++;
                end else if (!(raw_chars[0].drain && exp_tokens.size() != 0)) begin
                    tx_cur = raw_chars.pop_front();
                    tx_busy = 1'b1;
                    tx_gap_cnt = 0;
                end
            end
            s_axis_tvalid <= tx_busy;
            s_axis_tdata <= tx_cur.data;
            s_axis_tlast <= tx_cur.is_last;
        end
    end

    // receiver: random back-pressure and comparison against the oldest expectation
    int unsigned rx_stall_left = 0;
    bit          rx_calm = 1'b0;
    logic        rx_rdy;
    t_token      rx_want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_stall_left = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (exp_tokens.size() == 0) begin
                    $error("unexpected result: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
                    fail_cnt++;
                end else begin
                    rx_want = exp_tokens.pop_front();
                    if (m_axis_tdata[2:0] !== rx_want.kind) begin
                        $error("out_kind expected %0d actual %0d",
                               rx_want.kind, m_axis_tdata[2:0]);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[10:3] !== rx_want.data) begin
                        $error("out_byte expected %h actual %h",
                               rx_want.data, m_axis_tdata[10:3]);
                        fail_cnt++;
                    end
                    if (m_axis_tlast !== rx_want.is_last) begin
                        $error("out_last expected %b actual %b",
                               rx_want.is_last, m_axis_tlast);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[15:11] !== 5'd0) begin
                        $error("tdata padding expected 0 actual %h", m_axis_tdata[15:11]);
                        fail_cnt++;
                    end
                end
            end
            // stretches with no back-pressure at all
            if (cycle_cnt % 300 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            if (rx_stall_left != 0) begin
                rx_stall_left--;
                rx_rdy = 1'b0;
            end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
                rx_stall_left = pick_stall() - 1;
                rx_rdy = 1'b0;
            end else begin
                rx_rdy = 1'b1;
            end
            m_axis_tready <= rx_rdy;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        // directed: shortest strings with extreme bytes
        push_text("a");
        flush_string(1'b1, 1'b0);
        build_buf.push_back(8'h00);
        build_buf.push_back(8'hFF);
        flush_string(1'b0, 1'b0);
        // every delimiter, restarts, good and broken escapes, escape cut by the end
        push_text("?a=?=%41&&%zq=%4g%");
        flush_string(1'b0, 1'b0);
        // cut escape after one hex digit, pair without a value at the end
        push_text("x%4");
        flush_string(1'b1, 1'b0);

        build_random_string(1'b1);
        while (raw_chars.size() < ITEM_TARGET)
            build_random_string($urandom_range(0, 19) == 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (raw_chars.size() != 0 || tx_busy || s_axis_tvalid || exp_tokens.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
